@@ design/sig_rrip_pkg.sv @@
// Shared types and constants for the signature RRIP replacement engine.
`timescale 1ns / 1ps

package sig_rrip_pkg;

   // Engine geometry. Every size is a power of two, so set and way are taken
   // from the low bits of their fields.
   localparam int NUM_SETS      = 2048;
   localparam int NUM_WAYS      = 16;
   localparam int SIG_ENTRIES   = 2048;
   localparam int WINDOW_SLOTS  = 4;
   localparam int LEADER_COUNT  = 32;
   localparam int SELECTOR_BITS = 10;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_COMPARE,
      ST_CTR_READ,
      ST_CTR_WRITE,
      ST_CTR_READ2,
      ST_DECIDE,
      ST_RESPOND
   } state_type;

   // Command codes carried in the request user field.
   localparam logic CMD_VICTIM = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_STREAM_THRESHOLD = 1'b0;
   localparam logic CSR_REUSE_THRESHOLD  = 1'b1;
   localparam int   CSR_ADDR_W           = 1;
   localparam int   CSR_DATA_W           = 3;

   // Re-reference values and reuse counter limits.
   localparam logic [1:0] RRPV_TOP    = 2'd3;
   localparam logic [1:0] NEAR_INSERT = 2'd0;
   localparam logic [1:0] FAR_INSERT  = 2'd2;
   localparam logic [1:0] CTR_TOP     = 2'd3;
   localparam logic [1:0] CTR_ZERO    = 2'd0;
   localparam logic [1:0] CTR_INIT    = 2'd1;

   // Configuration reset values.
   localparam logic [2:0] STREAM_THR_INIT = 3'd3;
   localparam logic [1:0] REUSE_THR_INIT  = 2'd1;

   // Stream payload widths.
   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 24;
   localparam int ADDR_W     = 64;

endpackage

@@ design/signature_rrip_llc_replacement.sv @@
// Top level of the signature RRIP last-level cache replacement engine.
//
//   Channel  Ports       Direction  Contents
//   req      req_t*      in         one victim or update command per item
//   rsp      rsp_t*      out        one result per command
//   csr      csr_*       in         threshold register writes
//
// A victim item passes through accept, memory read, aging and write-back,
// and respond states. An update item adds delta compares through one shared
// comparator, one per window slot after the first, then a counter read and
// write, a second counter read on a miss, and a decide state before it responds.
// After reset a clearing pass over max(NUM_SETS, SIG_ENTRIES) entries
// initializes the memories; no item is taken until it ends. A stalled
// result holds the block in its respond state.
`timescale 1ns / 1ps

module signature_rrip_llc_replacement
   import sig_rrip_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // set_index[10:0], way[14:11], pc[78:15], paddr[142:79], hit[143]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd[0]
   input  logic [0:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // victim_way[3:0], streaming[4], insert_rrpv[6:5], duel_counter[16:7], zeros above
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SET_W      = $clog2(NUM_SETS);
   localparam int WAY_W      = $clog2(NUM_WAYS);
   localparam int SIG_W      = $clog2(SIG_ENTRIES);
   localparam int SLOT_W     = $clog2(WINDOW_SLOTS);
   localparam int CNT_W      = $clog2(WINDOW_SLOTS + 1);
   localparam int CLR_DEPTH  = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
   localparam int CLR_W      = $clog2(CLR_DEPTH);
   localparam int STRIDE_RAW = NUM_SETS / LEADER_COUNT;
   localparam int STRIDE     = (STRIDE_RAW == 0) ? 1 : STRIDE_RAW;
   localparam int STRIDE_W   = $clog2(STRIDE);
   localparam int LEAD_LIMIT = STRIDE * LEADER_COUNT;

   localparam logic [CLR_W-1:0]         CLR_LAST  = CLR_W'(CLR_DEPTH - 1);
   localparam logic [SLOT_W-1:0]        SLOT_LAST = SLOT_W'(WINDOW_SLOTS - 1);
   localparam logic [SELECTOR_BITS-1:0] SEL_TOP   = {SELECTOR_BITS{1'b1}};
   localparam logic [SELECTOR_BITS-1:0] SEL_INIT  = SEL_TOP >> 1;
   localparam logic [STRIDE_W-1:0]      HALF_LEAD = STRIDE_W'(STRIDE / 2);

   // Memories, one row per set or per signature.
   logic [NUM_WAYS-1:0][1:0]         rrpv_mem [NUM_SETS];
   logic [NUM_WAYS-1:0][SIG_W-1:0]   sig_mem  [NUM_SETS];
   logic [WINDOW_SLOTS-1:0][ADDR_W-1:0] win_mem [NUM_SETS];
   logic [ADDR_W-1:0]                last_mem [NUM_SETS];
   logic [SLOT_W-1:0]                ptr_mem  [NUM_SETS];
   logic [1:0]                       ctr_mem  [SIG_ENTRIES];

   // Sequencer and item registers.
   state_type                 state_ff, state_in;
   logic [CLR_W-1:0]          clr_ff, clr_in;
   logic                      cmd_ff, cmd_in;
   logic                      hit_ff, hit_in;
   logic [ADDR_W-1:0]         pc_ff, pc_in;
   logic [ADDR_W-1:0]         paddr_ff, paddr_in;
   logic [SET_W-1:0]          set_ff, set_in;
   logic [WAY_W-1:0]          way_ff, way_in;
   logic [SIG_W-1:0]          sig_ff, sig_in;

   // Memory read data and working copies.
   logic [NUM_WAYS-1:0][1:0]         rr_rd_ff;
   logic [NUM_WAYS-1:0][SIG_W-1:0]   sg_rd_ff;
   logic [WINDOW_SLOTS-1:0][ADDR_W-1:0] win_rd_ff;
   logic [ADDR_W-1:0]                last_rd_ff;
   logic [SLOT_W-1:0]                ptr_rd_ff;
   logic [1:0]                       ctr_rd_ff;
   logic [WINDOW_SLOTS-1:0][ADDR_W-1:0] win_ff, win_in;
   logic [SLOT_W-1:0]         cmp_idx_ff, cmp_idx_in;
   logic [CNT_W-1:0]          match_cnt_ff, match_cnt_in;
   logic [CNT_W-1:0]          match_cnt_next;
   logic                      stream_ff, stream_in;
   logic [SELECTOR_BITS-1:0]  sel_ff, sel_in;
   logic [SELECTOR_BITS-1:0]  sel_up;
   logic [2:0]                stream_thr_ff;
   logic [1:0]                reuse_thr_ff;

   // Result registers.
   logic [3:0]                rsp_victim_ff, rsp_victim_in;
   logic                      rsp_stream_ff, rsp_stream_in;
   logic [1:0]                rsp_ins_ff, rsp_ins_in;

   // Memory port controls.
   logic [SET_W-1:0]          mem_waddr;
   logic                      rr_we, sg_we, win_we, ctr_we, ctr_re;
   logic [NUM_WAYS-1:0][1:0]         rr_wdata;
   logic [NUM_WAYS-1:0][SIG_W-1:0]   sg_wdata;
   logic [WINDOW_SLOTS-1:0][ADDR_W-1:0] win_wdata;
   logic [ADDR_W-1:0]         last_wdata;
   logic [SLOT_W-1:0]         ptr_wdata;
   logic [SIG_W-1:0]          ctr_waddr, ctr_raddr;
   logic [1:0]                ctr_wdata;

   // Victim search and leader roles.
   logic [1:0]                rr_top;
   logic [1:0]                rr_add;
   logic [NUM_WAYS-1:0][1:0]  rr_aged;
   logic [WAY_W-1:0]          victim;
   logic                      near_lead, far_lead;
   logic                      in_leader_range;
   logic [SIG_W-1:0]          pc_hash;
   logic [1:0]                ins;
   logic                      slot_match;

   // Aging of the set's values and the first way at the top value.
   always_comb begin
      logic any3, any2, any1;
      any3 = 1'b0;
      any2 = 1'b0;
      any1 = 1'b0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         any3 = any3 | (rr_rd_ff[w] == 2'd3);
         any2 = any2 | (rr_rd_ff[w] == 2'd2);
         any1 = any1 | (rr_rd_ff[w] == 2'd1);
      end
      rr_top = any3 ? 2'd3 : (any2 ? 2'd2 : (any1 ? 2'd1 : 2'd0));
      rr_add = RRPV_TOP - rr_top;
      victim = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         rr_aged[w] = rr_rd_ff[w] + rr_add;
         if (rr_aged[w] == RRPV_TOP) begin
            victim = WAY_W'(w);
         end
      end
   end

   // Leader roles, PC hash and the shared window comparator.
   always_comb begin
      in_leader_range = (32'(set_ff) < LEAD_LIMIT);
      near_lead       = in_leader_range && (set_ff[STRIDE_W-1:0] == '0);
      far_lead        = in_leader_range && (set_ff[STRIDE_W-1:0] == HALF_LEAD);
      pc_hash         = pc_ff[SIG_W-1:0] ^ pc_ff[SIG_W+1:2] ^ pc_ff[SIG_W+4:5];
      slot_match      = (win_ff[cmp_idx_ff] == win_ff[0]);
      match_cnt_next  = match_cnt_ff + CNT_W'(slot_match);
      sel_up          = (near_lead && (sel_ff != SEL_TOP)) ? (sel_ff + 1'b1) : sel_ff;
   end

   // Insertion value on a miss.
   always_comb begin
      if (stream_ff) begin
         ins = FAR_INSERT;
      end else if (near_lead) begin
         ins = NEAR_INSERT;
      end else if (far_lead) begin
         ins = FAR_INSERT;
      end else if (ctr_rd_ff >= reuse_thr_ff) begin
         ins = NEAR_INSERT;
      end else begin
         ins = FAR_INSERT;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == CLR_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_READ;
         end
         ST_READ:      state_in = ST_LOAD;
         ST_LOAD:      state_in = (cmd_ff == CMD_UPDATE) ? ST_COMPARE : ST_RESPOND;
         ST_COMPARE: begin
            if (cmp_idx_ff == SLOT_LAST) state_in = ST_CTR_READ;
         end
         ST_CTR_READ:  state_in = ST_CTR_WRITE;
         ST_CTR_WRITE: state_in = hit_ff ? ST_DECIDE : ST_CTR_READ2;
         ST_CTR_READ2: state_in = ST_DECIDE;
         ST_DECIDE:    state_in = ST_RESPOND;
         ST_RESPOND: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory controls for each state.
   always_comb begin
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      hit_in        = hit_ff;
      pc_in         = pc_ff;
      paddr_in      = paddr_ff;
      set_in        = set_ff;
      way_in        = way_ff;
      sig_in        = sig_ff;
      win_in        = win_ff;
      cmp_idx_in    = cmp_idx_ff;
      match_cnt_in  = match_cnt_ff;
      stream_in     = stream_ff;
      sel_in        = sel_ff;
      rsp_victim_in = rsp_victim_ff;
      rsp_stream_in = rsp_stream_ff;
      rsp_ins_in    = rsp_ins_ff;
      mem_waddr     = set_ff;
      rr_we         = 1'b0;
      sg_we         = 1'b0;
      win_we        = 1'b0;
      ctr_we        = 1'b0;
      ctr_re        = 1'b0;
      rr_wdata      = rr_rd_ff;
      sg_wdata      = sg_rd_ff;
      win_wdata     = win_rd_ff;
      last_wdata    = paddr_ff;
      ptr_wdata     = (ptr_rd_ff == SLOT_LAST) ? '0 : (ptr_rd_ff + 1'b1);
      ctr_waddr     = sig_ff;
      ctr_raddr     = sig_ff;
      ctr_wdata     = ctr_rd_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in     = clr_ff + 1'b1;
            mem_waddr  = clr_ff[SET_W-1:0];
            rr_we      = (32'(clr_ff) < NUM_SETS);
            sg_we      = rr_we;
            win_we     = rr_we;
            rr_wdata   = '1;
            sg_wdata   = '0;
            win_wdata  = '0;
            last_wdata = '0;
            ptr_wdata  = '0;
            ctr_we     = (32'(clr_ff) < SIG_ENTRIES);
            ctr_waddr  = clr_ff[SIG_W-1:0];
            ctr_wdata  = CTR_INIT;
         end
         ST_IDLE: begin
            // Set and way wrap at the power-of-two sizes by taking low bits.
            cmd_in   = req_tuser[0];
            hit_in   = req_tdata[143];
            pc_in    = req_tdata[78:15];
            paddr_in = req_tdata[142:79];
            set_in   = req_tdata[SET_W-1:0];
            way_in   = req_tdata[11 +: WAY_W];
         end
         ST_READ: begin
            sig_in = pc_hash;
         end
         ST_LOAD: begin
            if (cmd_ff == CMD_UPDATE) begin
               // Record the new delta and advance the window pointer.
               win_wdata            = win_rd_ff;
               win_wdata[ptr_rd_ff] = paddr_ff - last_rd_ff;
               win_we               = 1'b1;
               win_in               = win_wdata;
               cmp_idx_in           = SLOT_W'(1);
               match_cnt_in         = CNT_W'(1);
            end else begin
               rr_wdata      = rr_aged;
               rr_we         = 1'b1;
               rsp_victim_in = victim;
               rsp_stream_in = 1'b0;
               rsp_ins_in    = NEAR_INSERT;
            end
         end
         ST_COMPARE: begin
            cmp_idx_in   = cmp_idx_ff + 1'b1;
            match_cnt_in = match_cnt_next;
            stream_in    = (win_ff[0] != '0) && (32'(match_cnt_next) >= 32'(stream_thr_ff));
         end
         ST_CTR_READ: begin
            ctr_re    = 1'b1;
            ctr_raddr = hit_ff ? sig_ff : sg_rd_ff[way_ff];
         end
         ST_CTR_WRITE: begin
            ctr_we = 1'b1;
            if (hit_ff) begin
               ctr_waddr = sig_ff;
               ctr_wdata = (ctr_rd_ff != CTR_TOP) ? (ctr_rd_ff + 1'b1) : ctr_rd_ff;
               sel_in    = (far_lead && (sel_up != '0)) ? (sel_up - 1'b1) : sel_up;
            end else begin
               ctr_waddr = sg_rd_ff[way_ff];
               ctr_wdata = (ctr_rd_ff != CTR_ZERO) ? (ctr_rd_ff - 1'b1) : ctr_rd_ff;
            end
         end
         ST_CTR_READ2: begin
            ctr_re    = 1'b1;
            ctr_raddr = sig_ff;
         end
         ST_DECIDE: begin
            rr_wdata[way_ff] = hit_ff ? NEAR_INSERT : ins;
            sg_wdata[way_ff] = sig_ff;
            rr_we            = 1'b1;
            sg_we            = 1'b1;
            rsp_victim_in    = 4'd0;
            rsp_stream_in    = stream_ff;
            rsp_ins_in       = hit_ff ? NEAR_INSERT : ins;
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         sel_ff   <= SEL_INIT;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         sel_ff   <= sel_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         stream_thr_ff <= STREAM_THR_INIT;
         reuse_thr_ff  <= REUSE_THR_INIT;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_STREAM_THRESHOLD: stream_thr_ff <= csr_wdata;
            CSR_REUSE_THRESHOLD:  reuse_thr_ff  <= csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      hit_ff        <= hit_in;
      pc_ff         <= pc_in;
      paddr_ff      <= paddr_in;
      set_ff        <= set_in;
      way_ff        <= way_in;
      sig_ff        <= sig_in;
      win_ff        <= win_in;
      cmp_idx_ff    <= cmp_idx_in;
      match_cnt_ff  <= match_cnt_in;
      stream_ff     <= stream_in;
      rsp_victim_ff <= rsp_victim_in;
      rsp_stream_ff <= rsp_stream_in;
      rsp_ins_ff    <= rsp_ins_in;
   end

   // Per-set memories: one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (rr_we) rrpv_mem[mem_waddr] <= rr_wdata;
      if (sg_we) sig_mem[mem_waddr] <= sg_wdata;
      if (win_we) begin
         win_mem[mem_waddr]  <= win_wdata;
         last_mem[mem_waddr] <= last_wdata;
         ptr_mem[mem_waddr]  <= ptr_wdata;
      end
      if (state_ff == ST_READ) begin
         rr_rd_ff   <= rrpv_mem[set_ff];
         sg_rd_ff   <= sig_mem[set_ff];
         win_rd_ff  <= win_mem[set_ff];
         last_rd_ff <= last_mem[set_ff];
         ptr_rd_ff  <= ptr_mem[set_ff];
      end
   end

   // Reuse counter memory.
   always_ff @(posedge clock) begin
      if (ctr_we) ctr_mem[ctr_waddr] <= ctr_wdata;
      if (ctr_re) ctr_rd_ff <= ctr_mem[ctr_raddr];
   end

   // Ports.
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESPOND);
   assign rsp_tdata  = {7'b0, sel_ff, rsp_ins_ff, rsp_stream_ff, rsp_victim_ff};

endmodule

@@ test/signature_rrip_llc_replacement_checker.sv @@
// Checker that predicts and compares every result of the replacement engine.
`timescale 1ns / 1ps

module signature_rrip_llc_replacement_checker
   import sig_rrip_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [0:0]            req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending
);

   localparam int SETS        = 2048;
   localparam int WAYS        = 16;
   localparam int SIGS        = 2048;
   localparam int SLOTS       = 4;
   localparam int LEAD_STRIDE = 64;

   typedef struct packed {
      logic [9:0] duel;
      logic [1:0] ins;
      logic       stream;
      logic [3:0] victim;
   } outcome_type;

   logic [1:0]  rrpv_mem [0:SETS-1][0:WAYS-1];
   logic [10:0] sig_mem [0:SETS-1][0:WAYS-1];
   logic [1:0]  reuse_ctr [0:SIGS-1];
   logic [9:0]  duel_sel;
   logic [63:0] delta_win [0:SETS-1][0:SLOTS-1];
   logic [63:0] prev_addr [0:SETS-1];
   logic [1:0]  win_ptr [0:SETS-1];
   logic [2:0]  stream_thr;
   logic [1:0]  reuse_thr;
   outcome_type outcome_q [$];

   // Works out the result of one accepted command and advances the shadow state.
   function automatic outcome_type replace_outcome(logic cmd, logic [REQ_DATA_W-1:0] d);
      outcome_type r;
      int          s, w, top, cnt;
      logic [63:0] pc, pa;
      logic [10:0] sig, old;
      logic        near, far;
      r = '0;
      s = int'(d[10:0]);
      w = int'(d[14:11]);
      pc = d[78:15];
      pa = d[142:79];
      near = (s % LEAD_STRIDE) == 0;
      far = (s % LEAD_STRIDE) == LEAD_STRIDE / 2;
      if (cmd == CMD_VICTIM) begin
         // Age the set until a way reaches the top value, then take the first one there.
         top = 0;
         for (int i = 0; i < WAYS; i++) if (rrpv_mem[s][i] > top) top = int'(rrpv_mem[s][i]);
         for (int i = 0; i < WAYS; i++) rrpv_mem[s][i] = 2'(int'(rrpv_mem[s][i]) + (3 - top));
         for (int i = WAYS - 1; i >= 0; i--) if (rrpv_mem[s][i] == RRPV_TOP) r.victim = 4'(i);
      end else begin
         sig = pc[10:0] ^ pc[12:2] ^ pc[15:5];
         // Record the address delta and look for a stream.
         delta_win[s][win_ptr[s]] = pa - prev_addr[s];
         win_ptr[s] = win_ptr[s] + 2'd1;
         prev_addr[s] = pa;
         if (delta_win[s][0] != 0) begin
            cnt = 1;
            for (int i = 1; i < SLOTS; i++) if (delta_win[s][i] == delta_win[s][0]) cnt++;
            r.stream = cnt >= stream_thr;
         end
         if (d[143]) begin
            r.ins = NEAR_INSERT;
            if (reuse_ctr[sig] != CTR_TOP) reuse_ctr[sig]++;
            if (near && duel_sel != 10'h3ff) duel_sel++;
            if (far && duel_sel != 0) duel_sel--;
         end else begin
            old = sig_mem[s][w];
            if (reuse_ctr[old] != CTR_ZERO) reuse_ctr[old]--;
            if (r.stream) r.ins = FAR_INSERT;
            else if (near) r.ins = NEAR_INSERT;
            else if (far) r.ins = FAR_INSERT;
            else r.ins = (reuse_ctr[sig] >= reuse_thr) ? NEAR_INSERT : FAR_INSERT;
         end
         rrpv_mem[s][w] = r.ins;
         sig_mem[s][w] = sig;
      end
      r.duel = duel_sel;
      return r;
   endfunction

   // Track configuration, predict on accepted commands, compare on accepted results.
   always @(posedge clock) begin
      outcome_type got, want;
      if (reset) begin
         for (int s = 0; s < SETS; s++) begin
            for (int w = 0; w < WAYS; w++) begin
               rrpv_mem[s][w] = RRPV_TOP;
               sig_mem[s][w] = '0;
            end
            for (int k = 0; k < SLOTS; k++) delta_win[s][k] = '0;
            prev_addr[s] = '0;
            win_ptr[s] = '0;
         end
         for (int k = 0; k < SIGS; k++) reuse_ctr[k] = CTR_INIT;
         duel_sel = 10'd511;
         stream_thr = STREAM_THR_INIT;
         reuse_thr = REUSE_THR_INIT;
         outcome_q.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_STREAM_THRESHOLD: stream_thr = csr_wdata;
               CSR_REUSE_THRESHOLD: reuse_thr = csr_wdata[1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) outcome_q.push_back(replace_outcome(req_tuser[0], req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[16:0];
            if (outcome_q.size() == 0) begin
               $error("unexpected item on result channel: %h", rsp_tdata);
               fail_count++;
            end else begin
               want = outcome_q.pop_front();
               if (got.victim !== want.victim) begin
                  $error("victim_way expected %0d actual %0d", want.victim, got.victim);
                  fail_count++;
               end
               if (got.stream !== want.stream) begin
                  $error("streaming expected %0d actual %0d", want.stream, got.stream);
                  fail_count++;
               end
               if (got.ins !== want.ins) begin
                  $error("insert_rrpv expected %0d actual %0d", want.ins, got.ins);
                  fail_count++;
               end
               if (got.duel !== want.duel) begin
                  $error("duel_counter expected %0d actual %0d", want.duel, got.duel);
                  fail_count++;
               end
               if (rsp_tdata[RSP_DATA_W-1:17] !== '0) begin
                  $error("padding expected 0 actual %h", rsp_tdata[RSP_DATA_W-1:17]);
                  fail_count++;
               end
            end
         end
      end
      pending = outcome_q.size();
   end

endmodule

@@ test/signature_rrip_llc_replacement_tb.sv @@
// Testbench top: drives commands and register writes, and reports the verdict.
`timescale 1ns / 1ps

module signature_rrip_llc_replacement_tb
   import sig_rrip_pkg::*;
();

   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_ITEMS = 345;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    fail_count;
   int                    pending;
   int                    send_idle = 0;
   int                    take_idle = 0;
   int                    cycles = 0;
   logic [63:0]           next_addr [0:2047];
   logic [63:0]           stride [0:2047];
   logic [63:0]           pc_pool [0:5];
   logic [10:0]           set_pool [0:7];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   signature_rrip_llc_replacement i_dut (.*);

   signature_rrip_llc_replacement_checker i_checker (.*);

   // The receiver stalls at random.
   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= take_idle);

   // Watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("signature_rrip_llc_replacement verification failed");
         $finish;
      end
   end

   // Offers one command and waits until it is taken.
   task automatic send_cmd(logic cmd, logic [10:0] s, logic [3:0] w, logic [63:0] pc,
                           logic [63:0] pa, logic h);
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {h, pa, pc, w, s};
      do @(posedge clock); while (!req_tready);
      if (cmd == CMD_UPDATE) next_addr[s] = pa + stride[s];
   endtask

   // Drops the request and lets the block finish everything outstanding.
   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   // One register write, after which the write port is left quiet.
   task automatic write_csr(logic [CSR_ADDR_W-1:0] a, logic [CSR_DATA_W-1:0] v);
      csr_we <= 1'b1;
      csr_addr <= a;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // One random item: mostly a small set and PC pool with strided addresses.
   task automatic random_cmd;
      logic [10:0] s;
      logic [63:0] pc, pa;
      s = ($urandom_range(99) < 70) ? set_pool[$urandom_range(7)] : 11'($urandom);
      pc = ($urandom_range(99) < 60) ? pc_pool[$urandom_range(5)] : {$urandom, $urandom};
      pa = ($urandom_range(99) < 70) ? next_addr[s] : {$urandom, $urandom};
      send_cmd(($urandom_range(99) < 30) ? CMD_VICTIM : CMD_UPDATE, s, 4'($urandom),
               pc, pa, 1'($urandom));
   endtask

   initial begin
      for (int s = 0; s < 2048; s++) begin
         next_addr[s] = {$urandom, $urandom};
         stride[s] = 64'($urandom_range(3, 1)) << 6;
      end
      for (int k = 0; k < 6; k++) pc_pool[k] = {$urandom, $urandom};
      set_pool = '{11'd0, 11'd32, 11'd64, 11'd96, 11'd5, 11'd777, 11'd1500, 11'd2047};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      send_idle = 33;
      take_idle = 78;

      // Directed: fresh victim, extremes of fields, leader sets, a stride run.
      send_cmd(CMD_VICTIM, 11'd0, 4'd0, '0, '0, 1'b0);
      send_cmd(CMD_UPDATE, 11'd0, 4'd0, '0, '0, 1'b1);
      send_cmd(CMD_UPDATE, 11'd2047, 4'd15, '1, '1, 1'b0);
      send_cmd(CMD_UPDATE, 11'd32, 4'd3, 64'h5555_5555_5555_5555, 64'h1000, 1'b1);
      send_cmd(CMD_UPDATE, 11'd32, 4'd4, 64'haaaa_aaaa_aaaa_aaaa, 64'h2000, 1'b0);
      send_cmd(CMD_UPDATE, 11'd64, 4'd5, '1, 64'h40, 1'b0);
      send_cmd(CMD_VICTIM, 11'd2047, 4'd15, '1, '1, 1'b1);
      send_cmd(CMD_VICTIM, 11'd0, 4'd9, '0, '0, 1'b0);
      for (int k = 0; k < 6; k++)
         send_cmd(CMD_UPDATE, 11'd5, 4'(k), pc_pool[0], 64'h8000 + 64'(k) * 64'h40, 1'b0);
      send_cmd(CMD_UPDATE, 11'd5, 4'd7, pc_pool[0], 64'h0, 1'b1);
      drain();
      write_csr(CSR_STREAM_THRESHOLD, 3'd0);
      write_csr(CSR_REUSE_THRESHOLD, 3'd0);
      for (int k = 0; k < 4; k++)
         send_cmd(CMD_UPDATE, 11'd777, 4'(k), pc_pool[1], 64'h10 * 64'(k + 1), 1'b0);
      send_cmd(CMD_UPDATE, 11'd777, 4'd8, pc_pool[1], 64'hffff_ffff_ffff_fff0, 1'b0);

      // Random phases under changing idling and register settings.
      for (int phase = 0; phase < 3; phase++) begin
         drain();
         case (phase)
            0: begin
               write_csr(CSR_STREAM_THRESHOLD, 3'd1);
               write_csr(CSR_REUSE_THRESHOLD, 3'd3);
            end
            1: begin
               write_csr(CSR_STREAM_THRESHOLD, 3'd4);
               write_csr(CSR_REUSE_THRESHOLD, 3'd2);
               send_idle = 78;
               take_idle = 33;
            end
            default: begin
               write_csr(CSR_STREAM_THRESHOLD, 3'd7);
               write_csr(CSR_REUSE_THRESHOLD, 3'd1);
               send_idle = 0;
               take_idle = 0;
            end
         endcase
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (phase == 2 && k == PHASE_ITEMS / 2) begin
               drain();
               write_csr(CSR_STREAM_THRESHOLD, 3'd2);
            end
            random_cmd();
         end
      end
      drain();

      if (fail_count == 0 && pending == 0) begin
         $display("signature_rrip_llc_replacement verification clean");
      end else begin
         $display("signature_rrip_llc_replacement verification failed");
      end
      $finish;
   end

endmodule

@@ signature_rrip_llc_replacement.f @@
design/sig_rrip_pkg.sv
design/signature_rrip_llc_replacement.sv
test/signature_rrip_llc_replacement_checker.sv
test/signature_rrip_llc_replacement_tb.sv
